// File: rtl/core/sssv_pkg.sv
// Shared types, codes and sizes for the safe-stop joint supervisor.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps

package sssv_pkg;

	localparam int JOINTS     = 6;
	localparam int POS_W      = 32;
	localparam int TGT_FIELDS = 6;
	localparam int CFG_W      = 16;
	localparam int CFG_IDX_W  = 2;
	localparam int JIDX_W     = (JOINTS > 1) ? $clog2(JOINTS) : 1;

	localparam logic [CFG_W-1:0] LAG_GAIN_RST    = 16'd3991;
	localparam logic [CFG_W-1:0] RATE_SCALE_RST  = 16'd500;
	localparam logic [CFG_W-1:0] RAMP_CYCLES_RST = 16'd150;

	localparam logic [CFG_IDX_W-1:0] REG_LAG_GAIN    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RATE_SCALE  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_RAMP_CYCLES = 2'd2;

	// flag bit positions
	localparam int FLG_CLIENT_LOST = 0;
	localparam int FLG_STOPPING    = 1;
	localparam int FLG_HOLDING     = 2;
	localparam int FLG_TELEM_LOST  = 3;

	typedef enum logic [2:0] {
		OP_CYCLE_END   = 3'd0,
		OP_WDOG_TRIP   = 3'd1,
		OP_SET_TARGET  = 3'd2,
		OP_STOP        = 3'd3,
		OP_DISABLE     = 3'd4,
		OP_CLEAR_FAULT = 3'd5
	} opcode_t;

	typedef enum logic [1:0] {
		MODE_IDLE  = 2'd0,
		MODE_TRACK = 2'd1,
		MODE_STOP  = 2'd2,
		MODE_HOLD  = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_STEP,
		ST_EMIT
	} ctrl_state_t;

	typedef struct packed {
		logic [2:0]        opcode;
		logic [2:0]        target_count;
		logic signed [31:0] target_j0;
		logic signed [31:0] target_j1;
		logic signed [31:0] target_j2;
		logic signed [31:0] target_j3;
		logic signed [31:0] target_j4;
		logic signed [31:0] target_j5;
		logic              publish_failed;
	} in_item_t;

	typedef struct packed {
		logic [2:0]         joint_index;
		logic [1:0]         mode;
		logic [3:0]         flags;
		logic signed [31:0] cmd_pos;
		logic signed [31:0] meas_pos;
		logic signed [31:0] meas_vel;
		logic               last;
	} out_item_t;

	typedef struct packed {
		logic              accept;  // input item taken this cycle
		logic              calc;    // register the lag step of joint jidx
		logic              emit;    // load the record of joint jidx
		logic [JIDX_W-1:0] jidx;
	} ctrl_cmd_t;

	typedef struct packed {
		logic out_free;
	} dp_status_t;

	function automatic logic signed [POS_W-1:0] target_field(in_item_t it, int k);
		logic signed [31:0] v;
		case (k)
			0:       v = it.target_j0;
			1:       v = it.target_j1;
			2:       v = it.target_j2;
			3:       v = it.target_j3;
			4:       v = it.target_j4;
			5:       v = it.target_j5;
			default: v = '0;
		endcase
		return POS_W'(v);
	endfunction

endpackage

// File: rtl/core/sssv_ctrl.sv
// Sequencer for the supervisor: takes items, walks the joints on a cycle end.
// Depends on sssv_pkg.
`timescale 1ns / 1ps

module sssv_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic [2:0]          in_opcode,
	output logic                in_stall,
	output sssv_pkg::ctrl_cmd_t cmd,
	input  sssv_pkg::dp_status_t status
);
	import sssv_pkg::*;

	ctrl_state_t       state_q, state_nxt;
	logic [JIDX_W-1:0] jidx_q;
	logic              accept;
	logic              last_joint;

	assign last_joint = (jidx_q == JIDX_W'(JOINTS - 1));

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid && in_opcode == OP_CYCLE_END) state_nxt = ST_STEP;
			end
			ST_STEP: state_nxt = ST_EMIT;
			ST_EMIT: begin
				if (status.out_free) state_nxt = last_joint ? ST_IDLE : ST_STEP;
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		in_stall   = (state_q != ST_IDLE);
		accept     = in_valid && !in_stall;
		cmd.accept = accept;
		cmd.calc   = (state_q == ST_STEP);
		cmd.emit   = (state_q == ST_EMIT) && status.out_free;
		cmd.jidx   = jidx_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			jidx_q  <= '0;
		end else begin
			state_q <= state_nxt;
			if (state_q == ST_IDLE) jidx_q <= '0;
			else if (cmd.emit && !last_joint) jidx_q <= jidx_q + JIDX_W'(1);
		end
	end

endmodule

// File: rtl/core/sssv_datapath.sv
// Supervisor datapath: mode state, joint arrays, config registers, lag and
// velocity unit, output register. Depends on sssv_pkg.
`timescale 1ns / 1ps

module sssv_datapath (
	input  logic                 clk,
	input  logic                 arst_n,
	input  sssv_pkg::in_item_t   in_item,
	input  logic                 cfg_we,
	input  logic [1:0]           cfg_index,
	input  logic [15:0]          cfg_data,
	input  sssv_pkg::ctrl_cmd_t  cmd,
	output sssv_pkg::dp_status_t status,
	output logic                 out_valid,
	input  logic                 out_stall,
	output sssv_pkg::out_item_t  out_item
);
	import sssv_pkg::*;

	localparam int HI_W  = POS_W + 1 - 16;
	localparam int SUM_W = HI_W + 17;
	localparam int PRD_W = POS_W + CFG_W;

	logic [CFG_W-1:0] lag_q, rate_q, ramp_cyc_q;
	mode_t            mode_q;
	logic [15:0]      ramp_q;
	logic             lost_q;
	logic [3:0]       flags_q;
	logic signed [POS_W-1:0] target_q [JOINTS];
	logic signed [POS_W-1:0] hold_q   [JOINTS];
	logic signed [POS_W-1:0] pos_q    [JOINTS];
	logic             out_valid_q;

	// stage 1: magnitude of the error times the gain, rounded
	logic signed [POS_W-1:0] pos_cur, tgt_cur;
	logic signed [POS_W:0]   diff;
	logic                    neg;
	logic [POS_W:0]          mag;
	logic [HI_W+15:0]        prod_hi;
	logic [32:0]             prod_lo;
	logic [SUM_W-1:0]        step_sum;

	logic [POS_W-1:0]        stp_s1;
	logic                    neg_s1;
	logic signed [POS_W-1:0] pos_s1, tgt_s1;

	// stage 2: next position and saturated velocity
	logic [PRD_W-1:0]        vprod;
	logic                    vsat;
	logic signed [POS_W-1:0] next_pos, vel;

	logic op_busy;
	logic load;

	assign pos_cur = pos_q[cmd.jidx];
	assign tgt_cur = target_q[cmd.jidx];

	always_comb begin
		diff     = {tgt_cur[POS_W-1], tgt_cur} - {pos_cur[POS_W-1], pos_cur};
		neg      = diff[POS_W];
		mag      = neg ? (POS_W+1)'(-diff) : (POS_W+1)'(diff);
		prod_hi  = (HI_W+16)'(mag[POS_W:16]) * (HI_W+16)'(lag_q);
		prod_lo  = 33'(mag[15:0]) * 33'(lag_q) + 33'd32768;
		step_sum = SUM_W'(prod_hi) + SUM_W'(prod_lo[32:16]);
	end

	always_comb begin
		vprod    = PRD_W'(stp_s1) * PRD_W'(rate_q);
		vsat     = |vprod[PRD_W-1:POS_W-1];
		next_pos = neg_s1 ? pos_s1 - $signed(stp_s1) : pos_s1 + $signed(stp_s1);
		if (vsat)
			vel = neg_s1 ? {1'b1, {(POS_W-1){1'b0}}} : {1'b0, {(POS_W-1){1'b1}}};
		else
			vel = neg_s1 ? -$signed(vprod[POS_W-1:0]) : $signed(vprod[POS_W-1:0]);
	end

	assign op_busy         = (mode_q == MODE_STOP) || (mode_q == MODE_HOLD);
	assign status.out_free = !out_valid_q || !out_stall;
	assign load            = cmd.emit;
	assign out_valid       = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lag_q       <= LAG_GAIN_RST;
			rate_q      <= RATE_SCALE_RST;
			ramp_cyc_q  <= RAMP_CYCLES_RST;
			mode_q      <= MODE_IDLE;
			ramp_q      <= '0;
			lost_q      <= 1'b0;
			flags_q     <= '0;
			out_valid_q <= 1'b0;
			for (int j = 0; j < JOINTS; j++) begin
				target_q[j] <= '0;
				hold_q[j]   <= '0;
				pos_q[j]    <= '0;
			end
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_LAG_GAIN:    lag_q      <= cfg_data;
					REG_RATE_SCALE:  rate_q     <= cfg_data;
					REG_RAMP_CYCLES: ramp_cyc_q <= cfg_data;
					default: ;
				endcase
			end

			if (cmd.accept) begin
				unique case (in_item.opcode)
					OP_CYCLE_END: begin
						lost_q <= 1'b0;
						flags_q[FLG_CLIENT_LOST] <= lost_q;
						flags_q[FLG_TELEM_LOST]  <= in_item.publish_failed;
						// a finished ramp reports holding instead of stopping
						flags_q[FLG_STOPPING]    <= (mode_q == MODE_STOP) &&
							(ramp_q < ramp_cyc_q);
						flags_q[FLG_HOLDING]     <= (mode_q == MODE_HOLD) ||
							((mode_q == MODE_STOP) && (ramp_q >= ramp_cyc_q));
						if (mode_q == MODE_STOP) begin
							for (int j = 0; j < JOINTS; j++) target_q[j] <= hold_q[j];
							if (ramp_q >= ramp_cyc_q) begin
								mode_q <= MODE_HOLD;
							end else begin
								if (ramp_q != 16'hFFFF) ramp_q <= ramp_q + 16'd1;
							end
						end
					end
					OP_WDOG_TRIP: begin
						mode_q <= MODE_STOP;
						ramp_q <= '0;
						lost_q <= 1'b1;
						for (int j = 0; j < JOINTS; j++) hold_q[j] <= pos_q[j];
					end
					OP_SET_TARGET: begin
						if (!op_busy) begin
							mode_q <= MODE_TRACK;
							for (int j = 0; j < JOINTS; j++) begin
								// joints past the input fields are never updated
								if (j < TGT_FIELDS && 3'(j) < in_item.target_count)
									target_q[j] <= target_field(in_item, j);
							end
						end
					end
					OP_STOP: begin
						if (!op_busy) begin
							mode_q <= MODE_STOP;
							ramp_q <= '0;
							for (int j = 0; j < JOINTS; j++) hold_q[j] <= pos_q[j];
						end
					end
					OP_DISABLE: begin
						if (!op_busy) mode_q <= MODE_IDLE;
					end
					OP_CLEAR_FAULT: begin
						if (mode_q == MODE_HOLD) mode_q <= MODE_IDLE;
					end
					default: ;
				endcase
			end

			if (load) pos_q[cmd.jidx] <= next_pos;

			if (load) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.calc) begin
			stp_s1 <= step_sum[POS_W-1:0];
			neg_s1 <= neg;
			pos_s1 <= pos_cur;
			tgt_s1 <= tgt_cur;
		end
		if (load) begin
			out_item.joint_index <= 3'(cmd.jidx);
			out_item.mode        <= mode_q;
			out_item.flags       <= flags_q;
			out_item.cmd_pos     <= 32'(tgt_s1);
			out_item.meas_pos    <= 32'(next_pos);
			out_item.meas_vel    <= 32'(vel);
			out_item.last        <= (cmd.jidx == JIDX_W'(JOINTS - 1));
		end
	end

endmodule

// File: rtl/core/safe_stop_joint_supervisor.sv
// Top level of the safe-stop joint supervisor: sequencer plus datapath.
// Depends on sssv_pkg, sssv_ctrl, sssv_datapath.
//
// Input channel (in_valid / in_stall / in_item) carries commands and
// cycle-end items. Commands are taken while in_stall is low and produce
// no record. A cycle-end item updates mode and flags at its accept edge,
// then runs one joint at a time through a single lag/velocity unit: for
// each joint, error times gain is registered (ST_STEP), then next position
// and velocity times rate are loaded into the record (ST_EMIT). A cycle
// end keeps in_stall high until the last joint's record is loaded, so the
// next item is taken only after that.
// Output channel (out_valid / out_stall / out_item) is one record register;
// while the receiver stalls, the joint walk pauses with the record held and
// the next input item can be taken once the last record is loaded.
// The cfg port writes lag_gain, rate_scale, ramp_cycles by index, others
// dropped. The user must write only while idle; the block does not check.
// Reset clears the mode to idle, all joint positions, targets and hold
// pose to zero, and loads the config defaults; no record is pending.
`timescale 1ns / 1ps

module safe_stop_joint_supervisor (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  sssv_pkg::in_item_t  in_item,
	output logic                out_valid,
	input  logic                out_stall,
	output sssv_pkg::out_item_t out_item,
	input  logic                cfg_we,
	input  logic [1:0]          cfg_index,
	input  logic [15:0]         cfg_data
);
	import sssv_pkg::*;

	ctrl_cmd_t  cmd;
	dp_status_t status;

	sssv_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_opcode (in_item.opcode),
		.in_stall  (in_stall),
		.cmd       (cmd),
		.status    (status)
	);

	sssv_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_item   (in_item),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.status    (status),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item)
	);

endmodule

// File: rtl/core/sssv_checker.sv
// Port-level checks for the supervisor, bound to the top level.
// Depends on sssv_pkg and safe_stop_joint_supervisor.
`timescale 1ns / 1ps

module sssv_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_stall,
	input sssv_pkg::in_item_t  in_item,
	input logic                out_valid,
	input logic                out_stall,
	input sssv_pkg::out_item_t out_item
);
	import sssv_pkg::*;

	// a stalled record holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_item))
		else $error("stalled output item changed");

	// last marks exactly the final joint
	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_item.last == (out_item.joint_index == 3'(JOINTS - 1)))
		else $error("last flag does not match joint index");

	// stopping and holding flags follow the reported mode
	a_flags_mode: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_item.flags[FLG_STOPPING] == (out_item.mode == MODE_STOP)) &&
		              (out_item.flags[FLG_HOLDING] == (out_item.mode == MODE_HOLD)))
		else $error("flags disagree with mode");

	// a command item produces no record
	a_cmd_silent: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && in_item.opcode != OP_CYCLE_END && !out_valid
		|=> !out_valid)
		else $error("record appeared after a command item");

	// no input is taken while a cycle end is still walking the joints
	a_walk_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && in_item.opcode == OP_CYCLE_END |=> in_stall)
		else $error("input taken during joint walk");

endmodule

bind safe_stop_joint_supervisor sssv_checker u_sssv_checker (.*);

// File: verif/tb.sv
// Self-checking testbench for safe_stop_joint_supervisor: a directed table, then
// mode-aware random items under five register settings, all checked by a local predictor.
// Depends on sssv_pkg and the supervisor RTL only.
`timescale 1ns / 1ps

module tb;
	import sssv_pkg::*;

	localparam logic [2:0]           OP_UNUSED_6 = 3'd6;
	localparam logic [2:0]           OP_UNUSED_7 = 3'd7;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED  = 2'd3;
	localparam int                   QUIET_LIMIT = 4000;
	localparam int                   ITEMS_PER_SETTING = 61;

	typedef logic signed [31:0] pose_t [TGT_FIELDS];

	typedef struct {
		in_item_t   item;
		bit         known;   // records fully known: given mode and flags, zero positions
		mode_t      k_mode;
		logic [3:0] k_flags;
	} plan_row_t;

	typedef struct {
		logic [15:0] gain;
		logic [15:0] rate;
		logic [15:0] ramp;
		int          idle;
	} setting_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	in_item_t    in_item = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	out_item_t   out_item;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = '0;
	logic [15:0] cfg_data = '0;

	// predictor state and register copies
	mode_t              sup_mode = MODE_IDLE;
	logic signed [31:0] sup_tgt  [JOINTS] = '{default: '0};
	logic signed [31:0] sup_hold [JOINTS] = '{default: '0};
	logic signed [31:0] sup_pos  [JOINTS] = '{default: '0};
	logic [15:0]        ramp_cnt = '0;
	bit                 lost_pend = 1'b0;
	logic [15:0]        gain_q16 = LAG_GAIN_RST;
	logic [15:0]        rate_hz  = RATE_SCALE_RST;
	logic [15:0]        ramp_len = RAMP_CYCLES_RST;

	out_item_t due_records[$];
	plan_row_t plan[$];
	setting_t  runs[5];
	int        idle_pct = 38;
	int        sent_items = 0;
	int        mismatches = 0;
	int        quiet_cycles = 0;

	pose_t pose_zero = '{default: '0};
	pose_t pose_ext  = '{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh0001_0000, -32'sd1,
		32'sh7FFF_0000, 32'sd0};
	pose_t pose_flip = '{32'sh8000_0000, 32'sh7FFF_FFFF, -32'sh0003_2000, 32'sh0000_8000,
		32'sd1, -32'sh7FFF_FFFF};
	pose_t pose_mid  = '{32'sh0000_C90F, -32'sh0001_921F, 32'sd0, 32'sh0002_0000,
		-32'sh0000_4000, 32'sh1234_5678};

	safe_stop_joint_supervisor uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_item(in_item),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_item(out_item),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < idle_pct);
	end

	task automatic begin_stop();
		sup_mode = MODE_STOP;
		ramp_cnt = '0;
		for (int j = 0; j < JOINTS; j++)
			sup_hold[j] = sup_pos[j];
	endtask

	// Applies one accepted item to the predictor and queues the joint records it causes.
	task automatic step_supervisor(input in_item_t it);
		pose_t              tv;
		logic [3:0]         fl;
		longint             d;
		longint             nxt;
		longint             vel;
		longint unsigned    m;
		longint unsigned    stp;
		longint unsigned    prod;
		bit                 neg;
		bit                 busy;
		out_item_t          rec;
		tv = '{it.target_j0, it.target_j1, it.target_j2, it.target_j3, it.target_j4,
			it.target_j5};
		busy = (sup_mode == MODE_STOP) || (sup_mode == MODE_HOLD);
		if (it.opcode == OP_WDOG_TRIP) begin
			begin_stop();
			lost_pend = 1'b1;
		end else if (it.opcode != OP_CYCLE_END) begin
			if (busy) begin
				if ((it.opcode == OP_CLEAR_FAULT) && (sup_mode == MODE_HOLD))
					sup_mode = MODE_IDLE;
			end else if (it.opcode == OP_SET_TARGET) begin
				for (int j = 0; j < it.target_count && j < TGT_FIELDS && j < JOINTS; j++)
					sup_tgt[j] = tv[j];
				sup_mode = MODE_TRACK;
			end else if (it.opcode == OP_STOP) begin
				begin_stop();
			end else if (it.opcode == OP_DISABLE) begin
				sup_mode = MODE_IDLE;
			end
		end else begin
			fl = '0;
			fl[FLG_CLIENT_LOST] = lost_pend;
			lost_pend = 1'b0;
			fl[FLG_TELEM_LOST] = it.publish_failed;
			if (sup_mode == MODE_STOP) begin
				fl[FLG_STOPPING] = 1'b1;
				for (int j = 0; j < JOINTS; j++)
					sup_tgt[j] = sup_hold[j];
				if (ramp_cnt >= ramp_len) begin
					sup_mode = MODE_HOLD;
					fl[FLG_STOPPING] = 1'b0;
					fl[FLG_HOLDING] = 1'b1;
				end else if (ramp_cnt != 16'hFFFF) begin
					ramp_cnt++;
				end
			end else if (sup_mode == MODE_HOLD) begin
				fl[FLG_HOLDING] = 1'b1;
			end
			for (int j = 0; j < JOINTS; j++) begin
				d = longint'(sup_tgt[j]) - longint'(sup_pos[j]);
				neg = d < 0;
				m = neg ? -d : d;
				// lag step rounds half away from zero on the magnitude
				stp = (m >> 16) * gain_q16 + (((m & 64'hFFFF) * gain_q16 + 64'd32768) >> 16);
				nxt = neg ? longint'(sup_pos[j]) - longint'(stp)
					: longint'(sup_pos[j]) + longint'(stp);
				if (rate_hz == 0 || stp == 0) begin
					vel = 0;
				end else begin
					prod = (stp > 64'h1_0000_0000 / rate_hz) ? 64'h1_0000_0000 : stp * rate_hz;
					if (neg)
						vel = (prod >= 64'h8000_0000) ? -longint'(64'h8000_0000) : -longint'(prod);
					else
						vel = (prod >= 64'h8000_0000) ? longint'(64'h7FFF_FFFF) : longint'(prod);
				end
				sup_pos[j] = nxt[31:0];
				rec.joint_index = 3'(j);
				rec.mode = sup_mode;
				rec.flags = fl;
				rec.cmd_pos = sup_tgt[j];
				rec.meas_pos = nxt[31:0];
				rec.meas_vel = vel[31:0];
				rec.last = (j == JOINTS - 1);
				due_records.push_back(rec);
			end
		end
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [15:0] v);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_LAG_GAIN:    gain_q16 = v;
			REG_RATE_SCALE:  rate_hz = v;
			REG_RAMP_CYCLES: ramp_len = v;
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic drive_item(input in_item_t it);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_item <= it;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		step_supervisor(it);
		sent_items++;
	endtask

	// drain before any register write; commands leave nothing to wait for
	task automatic settle();
		in_valid <= 1'b0;
		while (due_records.size() != 0)
			@(posedge clk);
		repeat (2 * JOINTS + 4) @(posedge clk);
	endtask

	function automatic in_item_t make_item(logic [2:0] op, logic [2:0] jc, pose_t p, bit pf);
		in_item_t it;
		it.opcode = op;
		it.target_count = jc;
		it.target_j0 = p[0];
		it.target_j1 = p[1];
		it.target_j2 = p[2];
		it.target_j3 = p[3];
		it.target_j4 = p[4];
		it.target_j5 = p[5];
		it.publish_failed = pf;
		return it;
	endfunction

	function automatic void add_row(logic [2:0] op, logic [2:0] jc, pose_t p, bit pf,
			bit known = 1'b0, mode_t km = MODE_IDLE, logic [3:0] kf = '0);
		plan_row_t r;
		r.item = make_item(op, jc, p, pf);
		r.known = known;
		r.k_mode = km;
		r.k_flags = kf;
		plan.push_back(r);
	endfunction

	function automatic logic signed [31:0] random_position();
		logic signed [31:0] v;
		case ($urandom_range(0, 4))
			0: v = $urandom;
			1: v = 32'sh7FFF_FFFF - $urandom_range(0, 3);
			2: v = 32'sh8000_0000 + $urandom_range(0, 3);
			default: begin
				v = $urandom_range(0, 32'h7FFFF);
				if ($urandom_range(0, 1))
					v = -v;
			end
		endcase
		return v;
	endfunction

	// Opcode mix follows the predicted mode so that stop ramps and holding get exercised.
	function automatic in_item_t next_random_item();
		pose_t      p;
		logic [2:0] op;
		logic [2:0] jc;
		int         r;
		foreach (p[k])
			p[k] = random_position();
		jc = $urandom_range(0, 1) ? 3'(JOINTS) : 3'($urandom_range(0, 7));
		r = $urandom_range(99);
		op = $urandom_range(0, 1) ? OP_UNUSED_6 : OP_UNUSED_7;
		case (sup_mode)
			MODE_IDLE: begin
				if (r < 55)      op = OP_SET_TARGET;
				else if (r < 65) op = OP_CYCLE_END;
				else if (r < 72) op = OP_WDOG_TRIP;
				else if (r < 78) op = OP_STOP;
				else if (r < 84) op = OP_DISABLE;
				else if (r < 92) op = OP_CLEAR_FAULT;
			end
			MODE_TRACK: begin
				if (r < 50)      op = OP_CYCLE_END;
				else if (r < 65) op = OP_SET_TARGET;
				else if (r < 75) op = OP_STOP;
				else if (r < 82) op = OP_WDOG_TRIP;
				else if (r < 88) op = OP_DISABLE;
				else if (r < 94) op = OP_CLEAR_FAULT;
			end
			MODE_STOP: begin
				if (r < 75)      op = OP_CYCLE_END;
				else if (r < 80) op = OP_WDOG_TRIP;
				else             op = 3'($urandom_range(OP_SET_TARGET, OP_UNUSED_7));
			end
			default: begin
				if (r < 45)      op = OP_CYCLE_END;
				else if (r < 80) op = OP_CLEAR_FAULT;
				else if (r < 85) op = OP_WDOG_TRIP;
				else             op = 3'($urandom_range(OP_SET_TARGET, OP_UNUSED_7));
			end
		endcase
		return make_item(op, jc, p, $urandom_range(0, 1));
	endfunction

	task automatic check_field(input string name, input longint want, input longint got);
		if (want != got) begin
			$error("%s: expected %0d, actual %0d", name, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk) begin
		out_item_t want;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (due_records.size() == 0) begin
					$error("joint record %0d arrived with none expected", out_item.joint_index);
					mismatches++;
				end else begin
					want = due_records.pop_front();
					check_field("joint_index", want.joint_index, out_item.joint_index);
					check_field("mode", want.mode, out_item.mode);
					check_field("flags", want.flags, out_item.flags);
					check_field("cmd_pos", want.cmd_pos, out_item.cmd_pos);
					check_field("meas_pos", want.meas_pos, out_item.meas_pos);
					check_field("meas_vel", want.meas_vel, out_item.meas_vel);
					check_field("last", want.last, out_item.last);
				end
			end
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
		end
	end

	initial begin
		int base;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// zero ramp: stopping turns into holding on the first cycle end
		write_reg(REG_RAMP_CYCLES, 16'd0);
		write_reg(REG_UNUSED, 16'hFFFF);

		add_row(OP_CYCLE_END, 3'd0, pose_zero, 1'b0, 1'b1, MODE_IDLE, '0);
		add_row(OP_CYCLE_END, 3'd0, pose_ext, 1'b1, 1'b1, MODE_IDLE,
			4'(1 << FLG_TELEM_LOST));
		add_row(OP_SET_TARGET, 3'd6, pose_ext, 1'b0);
		add_row(OP_CYCLE_END, 3'd0, pose_zero, 1'b0);
		add_row(OP_SET_TARGET, 3'd0, pose_mid, 1'b0);
		add_row(OP_SET_TARGET, 3'd7, pose_flip, 1'b1);
		add_row(OP_CYCLE_END, 3'd7, pose_mid, 1'b1);
		add_row(OP_UNUSED_6, 3'd6, pose_mid, 1'b1);
		add_row(OP_UNUSED_7, 3'd6, pose_ext, 1'b0);
		add_row(OP_CLEAR_FAULT, 3'd0, pose_zero, 1'b0);
		add_row(OP_STOP, 3'd0, pose_zero, 1'b0);
		add_row(OP_SET_TARGET, 3'd6, pose_mid, 1'b0);
		add_row(OP_DISABLE, 3'd0, pose_zero, 1'b0);
		add_row(OP_CYCLE_END, 3'd0, pose_zero, 1'b0);
		add_row(OP_CYCLE_END, 3'd0, pose_zero, 1'b1);
		add_row(OP_STOP, 3'd0, pose_zero, 1'b0);
		add_row(OP_WDOG_TRIP, 3'd0, pose_zero, 1'b0);
		add_row(OP_CYCLE_END, 3'd0, pose_zero, 1'b0);
		add_row(OP_CLEAR_FAULT, 3'd0, pose_zero, 1'b0);
		add_row(OP_DISABLE, 3'd0, pose_zero, 1'b0);
		add_row(OP_SET_TARGET, 3'd3, pose_mid, 1'b0);
		add_row(OP_DISABLE, 3'd0, pose_zero, 1'b0);
		add_row(OP_CYCLE_END, 3'd0, pose_zero, 1'b1);
		add_row(OP_WDOG_TRIP, 3'd0, pose_zero, 1'b0);
		add_row(OP_CYCLE_END, 3'd0, pose_zero, 1'b0);

		foreach (plan[i]) begin
			drive_item(plan[i].item);
			if (plan[i].known) begin
				for (int j = 0; j < JOINTS; j++) begin
					due_records[due_records.size() - JOINTS + j] = '{joint_index: 3'(j),
						mode: plan[i].k_mode, flags: plan[i].k_flags,
						last: (j == JOINTS - 1), default: '0};
				end
			end
		end
		settle();

		runs[0] = '{gain: LAG_GAIN_RST, rate: RATE_SCALE_RST, ramp: 16'd2, idle: 38};
		runs[1] = '{gain: 16'hFFFF, rate: 16'hFFFF, ramp: 16'd0, idle: 0};
		runs[2] = '{gain: 16'd0, rate: 16'd1, ramp: 16'hFFFF, idle: 38};
		runs[3] = '{gain: 16'h8000, rate: 16'd0, ramp: 16'd1, idle: 38};
		runs[4] = '{gain: 16'($urandom_range(0, 65535)), rate: 16'($urandom_range(1, 65535)),
			ramp: 16'($urandom_range(0, 6)), idle: 38};

		foreach (runs[p]) begin
			idle_pct = 38;
			write_reg(REG_LAG_GAIN, runs[p].gain);
			write_reg(REG_RATE_SCALE, runs[p].rate);
			write_reg(REG_RAMP_CYCLES, runs[p].ramp);
			idle_pct = runs[p].idle;
			base = sent_items;
			while (sent_items - base < ITEMS_PER_SETTING)
				drive_item(next_random_item());
			settle();
		end

		if (mismatches == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
